// ===== design/wdpg_pkg.sv =====
package wdpg_pkg;

    // largest buffer dimension; wider register values are clamped to it
    localparam int MaxDim = 4096;

    localparam int CoordW = 15;
    typedef logic signed [CoordW-1:0] t_coord;

    // configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CfgWindowWidth  = 3'd0;
    localparam t_cfg_idx CfgWindowHeight = 3'd1;
    localparam t_cfg_idx CfgBarHeight    = 3'd2;
    localparam t_cfg_idx CfgBorderWidth  = 3'd3;
    localparam t_cfg_idx CfgKnobSize     = 3'd4;
    localparam t_cfg_idx CfgKnobGap      = 3'd5;
    localparam t_cfg_idx CfgKnobInset    = 3'd6;

    localparam int CfgDataW = 13;

    // reset values
    localparam logic [12:0] RstWindowWidth  = 13'd0;
    localparam logic [12:0] RstWindowHeight = 13'd0;
    localparam logic [7:0]  RstBarHeight    = 8'd25;
    localparam logic [7:0]  RstBorderWidth  = 8'd5;
    localparam logic [7:0]  RstKnobSize     = 8'd15;
    localparam logic [7:0]  RstKnobGap      = 8'd3;
    localparam logic [7:0]  RstKnobInset    = 8'd5;

    // pointer area codes
    typedef logic [2:0] t_area;
    localparam t_area AreaNowhere  = 3'd0;
    localparam t_area AreaMinimize = 3'd2;
    localparam t_area AreaMaximize = 3'd3;
    localparam t_area AreaClose    = 3'd4;

    // colours, ARGB
    localparam logic [31:0] ColBlack   = 32'hff00_0000;
    localparam logic [31:0] ColFrame   = 32'h60aa_aaaa;
    localparam logic [31:0] ColHovered = 32'h20ee_eeee;
    localparam logic [31:0] ColPressed = 32'hff1f_1f1f;
    localparam logic [31:0] ColLit     = 32'hffff_ffff;
    localparam logic [31:0] ColClose   = 32'hff33_3333;
    localparam logic [31:0] ColMaxi    = 32'hff66_6666;
    localparam logic [31:0] ColMini    = 32'hffaa_aaaa;

    // one input item
    typedef struct packed {
        logic [11:0] pix_x;
        logic [11:0] pix_y;
        t_area       hover_area;
        logic        button_down;
        t_area       grab_area;
        logic        full_screen;
    } t_item;

    // precomputed decoration geometry
    typedef struct packed {
        logic   too_small;
        t_coord w;
        t_coord w_m1;
        t_coord w_bw;      // w - border_width
        t_coord h;
        t_coord h_m1;
        t_coord h_bw;      // h - border_width
        t_coord bw;
        t_coord bh;
        t_coord bh_m1;
        t_coord bh_bw;     // bar_height + border_width
        t_coord ki;
        t_coord ki_ks;     // first row below the buttons
        t_coord ki_ks_m1;  // last button row
        t_coord b1;
        t_coord b1_end;
        t_coord b1_last;
        t_coord b2;
        t_coord b2_end;
        t_coord b2_last;
        t_coord b3;
        t_coord b3_end;
        t_coord b3_last;
    } t_geom;

endpackage

// ===== design/wdpg_geom.sv =====
module wdpg_geom (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  wdpg_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [wdpg_pkg::CfgDataW-1:0] i_cfg_data,
    output wdpg_pkg::t_geom               o_geom
);

    logic [12:0] r_window_width;
    logic [12:0] r_window_height;
    logic [7:0]  r_bar_height;
    logic [7:0]  r_border_width;
    logic [7:0]  r_knob_size;
    logic [7:0]  r_knob_gap;
    logic [7:0]  r_knob_inset;

    wdpg_pkg::t_geom r_geom;
    wdpg_pkg::t_geom n_geom;

    function automatic wdpg_pkg::t_coord ext8(input logic [7:0] v);
        return wdpg_pkg::t_coord'({7'd0, v});
    endfunction

    function automatic wdpg_pkg::t_coord clamp_dim(input logic [12:0] v);
        logic [12:0] c;
        c = (v > 13'(wdpg_pkg::MaxDim)) ? 13'(wdpg_pkg::MaxDim) : v;
        return wdpg_pkg::t_coord'({2'd0, c});
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_width  <= wdpg_pkg::RstWindowWidth;
            r_window_height <= wdpg_pkg::RstWindowHeight;
            r_bar_height    <= wdpg_pkg::RstBarHeight;
            r_border_width  <= wdpg_pkg::RstBorderWidth;
            r_knob_size     <= wdpg_pkg::RstKnobSize;
            r_knob_gap      <= wdpg_pkg::RstKnobGap;
            r_knob_inset    <= wdpg_pkg::RstKnobInset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wdpg_pkg::CfgWindowWidth:  r_window_width  <= i_cfg_data;
                wdpg_pkg::CfgWindowHeight: r_window_height <= i_cfg_data;
                wdpg_pkg::CfgBarHeight:    r_bar_height    <= i_cfg_data[7:0];
                wdpg_pkg::CfgBorderWidth:  r_border_width  <= i_cfg_data[7:0];
                wdpg_pkg::CfgKnobSize:     r_knob_size     <= i_cfg_data[7:0];
                wdpg_pkg::CfgKnobGap:      r_knob_gap      <= i_cfg_data[7:0];
                wdpg_pkg::CfgKnobInset:    r_knob_inset    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        wdpg_pkg::t_coord ks;
        wdpg_pkg::t_coord kg;
        wdpg_pkg::t_coord knob_span;
        ks = ext8(r_knob_size);
        kg = ext8(r_knob_gap);

        n_geom.w     = clamp_dim(r_window_width);
        n_geom.h     = clamp_dim(r_window_height);
        n_geom.bw    = ext8(r_border_width);
        n_geom.bh    = ext8(r_bar_height);
        n_geom.ki    = ext8(r_knob_inset);
        n_geom.w_m1  = n_geom.w - 15'sd1;
        n_geom.h_m1  = n_geom.h - 15'sd1;
        n_geom.w_bw  = n_geom.w - n_geom.bw;
        n_geom.h_bw  = n_geom.h - n_geom.bw;
        n_geom.bh_m1 = n_geom.bh - 15'sd1;
        n_geom.bh_bw = n_geom.bh + n_geom.bw;
        n_geom.ki_ks = n_geom.ki + ks;
        n_geom.ki_ks_m1 = n_geom.ki_ks - 15'sd1;

        // buttons from the right: close, maximise, minimise
        n_geom.b1      = n_geom.w - n_geom.ki - ks;
        n_geom.b1_end  = n_geom.b1 + ks;
        n_geom.b1_last = n_geom.b1_end - 15'sd1;
        n_geom.b2      = n_geom.b1 - kg - ks;
        n_geom.b2_end  = n_geom.b2 + ks;
        n_geom.b2_last = n_geom.b2_end - 15'sd1;
        n_geom.b3      = n_geom.b2 - kg - ks;
        n_geom.b3_end  = n_geom.b3 + ks;
        n_geom.b3_last = n_geom.b3_end - 15'sd1;

        knob_span = (n_geom.ki <<< 1) + (kg <<< 1) + (ks <<< 1) + ks;
        n_geom.too_small = (n_geom.w < 15'sd2) || (n_geom.w < (n_geom.bw <<< 1))
                        || (n_geom.w < knob_span)
                        || (n_geom.h < (n_geom.bh + (n_geom.bw <<< 1)));
    end

    // geometry is registered from the configuration registers after a write
    always_ff @(posedge i_clk) begin
        r_geom <= n_geom;
    end

    assign o_geom = r_geom;

endmodule

// ===== design/wdpg_shade.sv =====
module wdpg_shade (
    input  wdpg_pkg::t_item i_item,
    input  wdpg_pkg::t_geom i_geom,
    output logic [31:0]     o_argb,
    output logic            o_written
);

    function automatic logic [31:0] knob_colour(
        input logic             edge_px,
        input wdpg_pkg::t_area  code,
        input logic [31:0]      idle,
        input wdpg_pkg::t_item  it
    );
        logic [31:0] c;
        if (edge_px) begin
            c = wdpg_pkg::ColBlack;
        end else if (it.hover_area == code && it.button_down && it.grab_area == code) begin
            c = wdpg_pkg::ColPressed;
        end else if (it.hover_area == code && !it.button_down) begin
            c = wdpg_pkg::ColLit;
        end else begin
            c = idle;
        end
        return c;
    endfunction

    always_comb begin
        wdpg_pkg::t_coord x;
        wdpg_pkg::t_coord y;
        logic        lr_edge;
        logic        row_edge;
        logic [31:0] col;
        logic        wr;

        x = wdpg_pkg::t_coord'({3'd0, i_item.pix_x});
        y = wdpg_pkg::t_coord'({3'd0, i_item.pix_y});
        lr_edge  = (x == 15'sd0) || (x == i_geom.w_m1);
        row_edge = (y == i_geom.ki) || (y == i_geom.ki_ks_m1);
        col = '0;
        wr  = 1'b0;

        if (!i_item.full_screen && x < i_geom.w && y < i_geom.h) begin
            if (i_geom.too_small) begin
                col = wdpg_pkg::ColBlack;
                wr  = 1'b1;
            end else begin
                // frame strips
                if (y >= i_geom.bh && y < i_geom.bh_bw) begin
                    col = lr_edge ? wdpg_pkg::ColBlack : wdpg_pkg::ColFrame;
                    wr  = 1'b1;
                end else if (y >= i_geom.h_bw) begin
                    col = (lr_edge || y == i_geom.h_m1) ? wdpg_pkg::ColBlack
                                                        : wdpg_pkg::ColFrame;
                    wr  = 1'b1;
                end else if (y >= i_geom.bh_bw) begin
                    if (x < i_geom.bw) begin
                        col = (x == 15'sd0) ? wdpg_pkg::ColBlack : wdpg_pkg::ColFrame;
                        wr  = 1'b1;
                    end else if (x >= i_geom.w_bw) begin
                        col = (x == i_geom.w_m1) ? wdpg_pkg::ColBlack
                                                 : wdpg_pkg::ColFrame;
                        wr  = 1'b1;
                    end
                end

                // control bar
                if (y < i_geom.bh) begin
                    if (y == 15'sd0 || y == i_geom.bh_m1 || lr_edge) begin
                        col = wdpg_pkg::ColBlack;
                    end else if (i_item.hover_area == wdpg_pkg::AreaNowhere) begin
                        col = wdpg_pkg::ColFrame;
                    end else begin
                        col = wdpg_pkg::ColHovered;
                    end
                    wr = 1'b1;
                end

                // buttons
                if (y >= i_geom.ki && y < i_geom.ki_ks) begin
                    if (x >= i_geom.b1 && x < i_geom.b1_end) begin
                        col = knob_colour(row_edge || x == i_geom.b1 || x == i_geom.b1_last,
                                          wdpg_pkg::AreaClose, wdpg_pkg::ColClose, i_item);
                        wr  = 1'b1;
                    end else if (x >= i_geom.b2 && x < i_geom.b2_end) begin
                        col = knob_colour(row_edge || x == i_geom.b2 || x == i_geom.b2_last,
                                          wdpg_pkg::AreaMaximize, wdpg_pkg::ColMaxi, i_item);
                        wr  = 1'b1;
                    end else if (x >= i_geom.b3 && x < i_geom.b3_end) begin
                        col = knob_colour(row_edge || x == i_geom.b3 || x == i_geom.b3_last,
                                          wdpg_pkg::AreaMinimize, wdpg_pkg::ColMini, i_item);
                        wr  = 1'b1;
                    end
                end
            end
        end

        o_argb    = wr ? col : 32'd0;
        o_written = wr;
    end

endmodule

// ===== design/window_decoration_pixel_gen_unit.sv =====
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ------------------------------------------
// item in   input      start, busy (always low)  i_pix_x, i_pix_y, i_hover_area,
//                                                i_button_down, i_grab_area, i_full_screen
// result    output     o_strobe, one cycle       o_pixel_argb, o_pixel_written
// config    input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One item per clock, sustained; each result passes the input register, decoration logic and
// result reg before it sits on the outputs. Config writes pass the config registers and then
// the geometry register; issue items from then on.
// Synchronous active-low reset clears the valid flags and restores register defaults.
// busy never rises and the receiver cannot stall, so no item is ever held back.
module window_decoration_pixel_gen_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item channel
    input  logic                          start,
    output logic                          busy,
    input  logic [11:0]                   i_pix_x,
    input  logic [11:0]                   i_pix_y,
    input  logic [2:0]                    i_hover_area,
    input  logic                          i_button_down,
    input  logic [2:0]                    i_grab_area,
    input  logic                          i_full_screen,
    // result channel
    output logic                          o_strobe,
    output logic [31:0]                   o_pixel_argb,
    output logic                          o_pixel_written,
    // configuration
    input  logic                          i_cfg_we,
    input  wdpg_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [wdpg_pkg::CfgDataW-1:0] i_cfg_data
);

    wdpg_pkg::t_geom geom;
    wdpg_pkg::t_item r_item;
    logic            r_item_vld;
    logic [31:0]     shade_argb;
    logic            shade_written;
    logic [31:0]     r_argb;
    logic            r_written;
    logic            r_out_vld;
    logic            accept;

    // no internal back-pressure: the pipe moves every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    wdpg_geom u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_geom     (geom)
    );

    // input register: payload unreset, valid flag cleared
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.pix_x       <= i_pix_x;
            r_item.pix_y       <= i_pix_y;
            r_item.hover_area  <= i_hover_area;
            r_item.button_down <= i_button_down;
            r_item.grab_area   <= i_grab_area;
            r_item.full_screen <= i_full_screen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_item_vld <= accept;
            r_out_vld  <= r_item_vld;
        end
    end

    // frame, bar and button layers, last one wins
    wdpg_shade u_shade (
        .i_item    (r_item),
        .i_geom    (geom),
        .o_argb    (shade_argb),
        .o_written (shade_written)
    );

    // result register
    always_ff @(posedge i_clk) begin
        r_argb    <= shade_argb;
        r_written <= shade_written;
    end

    assign o_strobe        = r_out_vld;
    assign o_pixel_argb    = r_argb;
    assign o_pixel_written = r_written;

`ifndef NO_ASSERTIONS
    // every taken item yields a result through the input and result registers
    a_item_to_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_strobe)
        else $error("item taken without a result");

    // no result without an item taken ahead of it
    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, 2))
        else $error("result without an item");

    // fullscreen items never paint
    a_fullscreen : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_full_screen) |=> ##1 !o_pixel_written)
        else $error("pixel painted in fullscreen");

    // unpainted pixels carry a zero colour
    a_unwritten_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_pixel_written) |-> (o_pixel_argb == 32'd0))
        else $error("unpainted pixel with nonzero colour");
`endif

endmodule

// ===== verif/tb_window_decoration_pixel_gen_unit.sv =====
module tb_window_decoration_pixel_gen_unit;
    import wdpg_pkg::*;

    // generous ceiling: ~2000 items, each with its worst idle gap, plus config and drain pauses
    localparam int CycleLimit = 400000;

    // area codes the package leaves unnamed
    localparam t_area AreaOther = 3'd1;    // pointer somewhere, not on a button
    localparam t_area AreaSpare = 3'd6;    // unused code, behaves like "other"

    // register index with no register behind it; writes must be ignored
    localparam t_cfg_idx CfgUnused = 3'd7;

    // one painted pixel as the block reports it
    typedef struct packed {
        logic [31:0] argb;
        logic        written;
    } t_paint;

    // ---------------------------------------------------------------
    // clock, reset, DUT ports
    // ---------------------------------------------------------------
    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    t_item               cur_item = '0;
    logic                o_strobe;
    logic [31:0]         o_pixel_argb;
    logic                o_pixel_written;
    logic                cfg_we   = 1'b0;
    t_cfg_idx            cfg_idx  = CfgWindowWidth;
    logic [CfgDataW-1:0] cfg_data = '0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    window_decoration_pixel_gen_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_pix_x         (cur_item.pix_x),
        .i_pix_y         (cur_item.pix_y),
        .i_hover_area    (cur_item.hover_area),
        .i_button_down   (cur_item.button_down),
        .i_grab_area     (cur_item.grab_area),
        .i_full_screen   (cur_item.full_screen),
        .o_strobe        (o_strobe),
        .o_pixel_argb    (o_pixel_argb),
        .o_pixel_written (o_pixel_written),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    // ---------------------------------------------------------------
    // shadow copy of the geometry registers
    // ---------------------------------------------------------------
    logic [12:0] win_w    = RstWindowWidth;
    logic [12:0] win_h    = RstWindowHeight;
    logic [7:0]  bar_h    = RstBarHeight;
    logic [7:0]  border_w = RstBorderWidth;
    logic [7:0]  knob_sz  = RstKnobSize;
    logic [7:0]  knob_gp  = RstKnobGap;
    logic [7:0]  knob_in  = RstKnobInset;

    t_item  coords_todo_q[$];   // items waiting for the driver
    t_paint pixels_due_q[$];    // colours owed by the block, oldest first

    int   coords_queued = 0;
    int   coords_taken  = 0;
    int   fail_cnt      = 0;
    int   cycle_cnt     = 0;
    int   gap_left      = 0;
    int   idle_pct      = 0;
    logic item_taken    = 1'b0;

    // ---------------------------------------------------------------
    // pixel predictor
    // ---------------------------------------------------------------

    // button face: black outline, then pressed / lit / idle fill
    function automatic logic [31:0] knob_fill(int x, int x0, int row, int ks, t_area code,
                                              logic [31:0] idle, t_item it);
        if (row == 0 || row == ks - 1 || x == x0 || x == x0 + ks - 1)
            return ColBlack;
        if (it.hover_area == code && it.button_down && it.grab_area == code)
            return ColPressed;
        if (it.hover_area == code && !it.button_down)
            return ColLit;
        return idle;
    endfunction

    function automatic t_paint decorate_pixel(t_item it);
        int          x, y, w, h, bh, bw, ks, kg, ki, b1, b2, b3, row;
        logic [31:0] col;
        logic        wr;
        t_paint      px;
        x  = it.pix_x;
        y  = it.pix_y;
        w  = (win_w > MaxDim) ? MaxDim : win_w;
        h  = (win_h > MaxDim) ? MaxDim : win_h;
        bh = bar_h;
        bw = border_w;
        ks = knob_sz;
        kg = knob_gp;
        ki = knob_in;
        col = '0;
        wr  = 1'b0;
        if (!it.full_screen && x < w && y < h) begin
            if (w < 2 || w < 2 * bw || w < 2 * ki + 2 * kg + 3 * ks || h < bh + 2 * bw) begin
                // window too small: solid black
                col = ColBlack;
                wr  = 1'b1;
            end else begin
                b1 = w - ki - ks;
                b2 = b1 - kg - ks;
                b3 = b2 - kg - ks;
                // frame strips
                if (y >= bh && y < bh + bw) begin
                    col = (x == 0 || x == w - 1) ? ColBlack : ColFrame;
                    wr  = 1'b1;
                end else if (y >= h - bw) begin
                    col = (x == 0 || x == w - 1 || y == h - 1) ? ColBlack : ColFrame;
                    wr  = 1'b1;
                end else if (y >= bh + bw) begin
                    if (x < bw) begin
                        col = (x == 0) ? ColBlack : ColFrame;
                        wr  = 1'b1;
                    end else if (x >= w - bw) begin
                        col = (x == w - 1) ? ColBlack : ColFrame;
                        wr  = 1'b1;
                    end
                end
                // control bar overrides the frame
                if (y < bh) begin
                    if (y == 0 || y == bh - 1 || x == 0 || x == w - 1)
                        col = ColBlack;
                    else
                        col = (it.hover_area == AreaNowhere) ? ColFrame : ColHovered;
                    wr = 1'b1;
                end
                // buttons sit on top of everything; rows fixed by the inset
                if (y >= ki && y < ki + ks) begin
                    row = y - ki;
                    if (x >= b1 && x < b1 + ks) begin
                        col = knob_fill(x, b1, row, ks, AreaClose, ColClose, it);
                        wr  = 1'b1;
                    end else if (x >= b2 && x < b2 + ks) begin
                        col = knob_fill(x, b2, row, ks, AreaMaximize, ColMaxi, it);
                        wr  = 1'b1;
                    end else if (x >= b3 && x < b3 + ks) begin
                        col = knob_fill(x, b3, row, ks, AreaMinimize, ColMini, it);
                        wr  = 1'b1;
                    end
                end
            end
        end
        px.argb    = wr ? col : '0;
        px.written = wr;
        return px;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic t_item mk_item(int x, int y, t_area hov, logic down, t_area grab,
                                      logic full);
        t_item it;
        it.pix_x       = 12'(x);
        it.pix_y       = 12'(y);
        it.hover_area  = hov;
        it.button_down = down;
        it.grab_area   = grab;
        it.full_screen = full;
        return it;
    endfunction

    // random pixel, mostly aimed at the edges of frame, bar and buttons
    function automatic t_item rand_pixel();
        t_item it;
        int    w, h, bh, bw, ks, kg, ki, b1, b2, b3, x, y;
        w  = (win_w > MaxDim) ? MaxDim : win_w;
        h  = (win_h > MaxDim) ? MaxDim : win_h;
        bh = bar_h;
        bw = border_w;
        ks = knob_sz;
        kg = knob_gp;
        ki = knob_in;
        b1 = w - ki - ks;
        b2 = b1 - kg - ks;
        b3 = b2 - kg - ks;
        case ($urandom_range(0, 9))
            0: x = $urandom_range(0, 4095);
            1, 2, 3: x = $urandom_range(0, w + 1);
            default: begin
                case ($urandom_range(0, 9))
                    0: x = 0;
                    1: x = w - 1;
                    2: x = bw;
                    3: x = w - bw;
                    4: x = b1;
                    5: x = b1 + ks - 1;
                    6: x = b2;
                    7: x = b2 + ks - 1;
                    8: x = b3;
                    default: x = b3 + ks - 1;
                endcase
                x += int'($urandom_range(0, 2)) - 1;
            end
        endcase
        case ($urandom_range(0, 9))
            0: y = $urandom_range(0, 4095);
            1, 2, 3: y = $urandom_range(0, h + 1);
            default: begin
                case ($urandom_range(0, 9))
                    0: y = 0;
                    1: y = bh - 1;
                    2: y = bh;
                    3: y = bh + bw;
                    4: y = h - bw;
                    5: y = h - 1;
                    6: y = ki;
                    7: y = ki + ks - 1;
                    8: y = ki + ks;
                    default: y = h;
                endcase
                y += int'($urandom_range(0, 2)) - 1;
            end
        endcase
        if (x < 0) x = 0;
        if (x > 4095) x = 4095;
        if (y < 0) y = 0;
        if (y > 4095) y = 4095;
        // favour button codes and matching grabs so pressed faces turn up
        it = mk_item(x, y, AreaNowhere, 1'($urandom_range(0, 1)), AreaNowhere,
                     $urandom_range(0, 15) == 0);
        it.hover_area = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                    : 3'($urandom_range(AreaMinimize, AreaClose));
        it.grab_area  = ($urandom_range(0, 1) == 0) ? it.hover_area : 3'($urandom_range(0, 7));
        return it;
    endfunction

    task automatic push_item(t_item it);
        coords_todo_q.push_back(it);
        coords_queued++;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CfgDataW-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CfgWindowWidth:  win_w    = val;
            CfgWindowHeight: win_h    = val;
            CfgBarHeight:    bar_h    = val[7:0];
            CfgBorderWidth:  border_w = val[7:0];
            CfgKnobSize:     knob_sz  = val[7:0];
            CfgKnobGap:      knob_gp  = val[7:0];
            CfgKnobInset:    knob_in  = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // all seven registers; 'noisy' sets junk in the unused top bits of the byte regs
    task automatic set_geometry(int w, int h, int bh, int bw, int ks, int kg, int ki,
                                logic noisy);
        logic [CfgDataW-1:0] junk;
        junk = noisy ? {5'($urandom), 8'h00} : '0;
        write_reg(CfgWindowWidth, 13'(w));
        write_reg(CfgWindowHeight, 13'(h));
        write_reg(CfgBarHeight, junk | 13'(bh & 8'hff));
        write_reg(CfgBorderWidth, junk | 13'(bw & 8'hff));
        write_reg(CfgKnobSize, junk | 13'(ks & 8'hff));
        write_reg(CfgKnobGap, junk | 13'(kg & 8'hff));
        write_reg(CfgKnobInset, junk | 13'(ki & 8'hff));
        write_reg(CfgUnused, 13'($urandom));
        // let the last write pass the configuration and geometry registers
        repeat (2) @(negedge i_clk);
    endtask

    task automatic rand_config();
        int   bh, bw, ks, kg, ki, minw, minh, w, h;
        logic big;
        big = ($urandom_range(0, 7) == 0);
        bh  = big ? $urandom_range(0, 255) : $urandom_range(0, 40);
        bw  = big ? $urandom_range(0, 255) : $urandom_range(0, 12);
        ks  = big ? $urandom_range(0, 255) : $urandom_range(0, 20);
        kg  = big ? $urandom_range(0, 255) : $urandom_range(0, 8);
        ki  = big ? $urandom_range(0, 255) : $urandom_range(0, 10);
        minw = 2;
        if (2 * bw > minw) minw = 2 * bw;
        if (2 * ki + 2 * kg + 3 * ks > minw) minw = 2 * ki + 2 * kg + 3 * ks;
        minh = bh + 2 * bw;
        case ($urandom_range(0, 9))
            0: w = $urandom_range(0, 8191);
            1: w = minw - 1;                      // one short of the minimum
            default: w = minw + $urandom_range(0, 60);
        endcase
        case ($urandom_range(0, 9))
            0: h = $urandom_range(0, 8191);
            1: h = minh - 1;
            default: h = minh + $urandom_range(0, 40);
        endcase
        if (w < 0) w = 0;
        if (h < 0) h = 0;
        if (w > 8191) w = 8191;
        if (h > 8191) h = 8191;
        set_geometry(w, h, bh, bw, ks, kg, ki, $urandom_range(0, 3) == 0);
    endtask

    // block is idle once every queued item is taken and every colour has come back
    task automatic drain();
        while (coords_taken != coords_queued || pixels_due_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // driver: feeds the item port at the falling edge
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !item_taken) begin
            // item still on offer; hold it
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
        end else if (coords_todo_q.size() != 0) begin
            cur_item <= coords_todo_q.pop_front();
            start    <= 1'b1;
            if ($urandom_range(0, 99) < idle_pct)
                gap_left <= $urandom_range(1, 9);
        end else begin
            start <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // monitor: checks colours, then logs newly taken items
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_paint due;
        item_taken <= i_rst_n && start && !busy;
        if (i_rst_n && o_strobe) begin
            if (pixels_due_q.size() == 0) begin
                $error("pixel result with no item outstanding");
                fail_cnt++;
            end else begin
                due = pixels_due_q.pop_front();
                if (o_pixel_argb !== due.argb) begin
                    $error("pixel_argb: expected %h, got %h", due.argb, o_pixel_argb);
                    fail_cnt++;
                end
                if (o_pixel_written !== due.written) begin
                    $error("pixel_written: expected %b, got %b", due.written, o_pixel_written);
                    fail_cnt++;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            pixels_due_q.push_back(decorate_pixel(cur_item));
            coords_taken++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // reset geometry: zero-sized buffer, nothing painted
        push_item(mk_item(0, 0, AreaNowhere, 1'b0, AreaNowhere, 1'b0));
        drain();

        // 640x480, default decoration; buttons at x 620 (close), 602, 584, rows 5..19
        set_geometry(640, 480, 25, 5, 15, 3, 5, 1'b0);
        push_item(mk_item(0, 0, AreaNowhere, 1'b0, AreaNowhere, 1'b0));     // bar corner
        push_item(mk_item(100, 10, AreaNowhere, 1'b0, AreaNowhere, 1'b0));  // bar, no hover
        push_item(mk_item(100, 10, AreaOther, 1'b0, AreaNowhere, 1'b0));    // bar, hovered
        push_item(mk_item(100, 27, AreaNowhere, 1'b0, AreaNowhere, 1'b0));  // strip under bar
        push_item(mk_item(0, 100, AreaNowhere, 1'b0, AreaNowhere, 1'b0));   // left outline
        push_item(mk_item(2, 100, AreaNowhere, 1'b0, AreaNowhere, 1'b0));   // left frame
        push_item(mk_item(637, 100, AreaNowhere, 1'b0, AreaNowhere, 1'b0)); // right frame
        push_item(mk_item(639, 100, AreaNowhere, 1'b0, AreaNowhere, 1'b0)); // right outline
        push_item(mk_item(300, 300, AreaNowhere, 1'b0, AreaNowhere, 1'b0)); // client area
        push_item(mk_item(300, 479, AreaNowhere, 1'b0, AreaNowhere, 1'b0)); // bottom outline
        push_item(mk_item(300, 476, AreaNowhere, 1'b0, AreaNowhere, 1'b0)); // bottom frame
        push_item(mk_item(620, 10, AreaClose, 1'b0, AreaNowhere, 1'b0));    // close outline
        push_item(mk_item(625, 10, AreaClose, 1'b0, AreaNowhere, 1'b0));    // close lit
        push_item(mk_item(625, 10, AreaClose, 1'b1, AreaClose, 1'b0));      // close pressed
        push_item(mk_item(625, 10, AreaClose, 1'b1, AreaMinimize, 1'b0));   // grabbed elsewhere
        push_item(mk_item(608, 12, AreaMaximize, 1'b0, AreaNowhere, 1'b0)); // maximize lit
        push_item(mk_item(590, 12, AreaMinimize, 1'b1, AreaMinimize, 1'b0));// minimize pressed
        push_item(mk_item(625, 10, AreaSpare, 1'b0, AreaSpare, 1'b0));      // spare hover code
        push_item(mk_item(0, 0, AreaNowhere, 1'b0, AreaNowhere, 1'b1));     // fullscreen
        push_item(mk_item(640, 0, AreaNowhere, 1'b0, AreaNowhere, 1'b0));   // past right edge
        push_item(mk_item(4095, 4095, AreaSpare, 1'b1, AreaClose, 1'b0));   // far outside
        drain();

        // too narrow: the buffer goes black, outside stays untouched
        set_geometry(1, 100, 25, 5, 15, 3, 5, 1'b0);
        push_item(mk_item(0, 5, AreaNowhere, 1'b0, AreaNowhere, 1'b0));
        push_item(mk_item(1, 5, AreaNowhere, 1'b0, AreaNowhere, 1'b0));
        drain();

        // oversized buffer clamps to MaxDim, byte registers at their maximum
        set_geometry(8191, 8191, 255, 255, 255, 255, 255, 1'b0);
        push_item(mk_item(4095, 4095, AreaNowhere, 1'b0, AreaNowhere, 1'b0));
        drain();

        // all decoration sizes zero: nothing to draw
        set_geometry(8, 4, 0, 0, 0, 0, 0, 1'b0);
        push_item(mk_item(3, 2, AreaClose, 1'b0, AreaNowhere, 1'b0));
        drain();

        // random phases; idling varies per phase, none in the final two
        for (int p = 0; p < 12; p++) begin
            case (p % 3)
                0: idle_pct = 0;
                1: idle_pct = 15;
                default: idle_pct = 45;
            endcase
            if (p >= 10)
                idle_pct = 0;
            rand_config();
            for (int n = 0; n < 150; n++)
                push_item(rand_pixel());
            // sender waits for every owed colour before the geometry changes
            drain();
        end

        if (fail_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
